[sv/irenc_pkg.sv]
// shared types and constants for the ir command frame encoder
package irenc_pkg;

  localparam logic [7:0] HdrByte0  = 8'h55;
  localparam logic [7:0] HdrByte1  = 8'hFF;
  localparam logic [7:0] HdrByte2  = 8'h00;
  localparam logic [7:0] AltOffset = 8'h08;

  typedef struct packed {
    logic [7:0] data;
    logic       opens;
    logic       closes;
    logic [7:0] sum;
  } entry_t;

  typedef enum logic [6:0] {
    StHdr0  = 7'b0000001,
    StHdr1  = 7'b0000010,
    StHdr2  = 7'b0000100,
    StData  = 7'b0001000,
    StDataN = 7'b0010000,
    StSum   = 7'b0100000,
    StSumN  = 7'b1000000
  } step_e;

endpackage

[sv/irenc_front.sv]
// front end: accepts message bytes, applies the toggle and keeps the checksum
module irenc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              starts_frame_i,
  input  logic              ends_frame_i,
  input  logic              full_i,
  output logic              push_o,
  output irenc_pkg::entry_t push_entry_o
);

  logic       toggle_q, toggle_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] data_adj;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    data_adj = data_byte_i;
    toggle_d = toggle_q;
    if (starts_frame_i) begin
      if (toggle_q) begin
        data_adj = data_byte_i + irenc_pkg::AltOffset;
      end
      toggle_d = !toggle_q;
      sum_d    = data_adj;
    end else begin
      sum_d = sum_q + data_byte_i;
    end
  end

  assign push_entry_o.data   = data_adj;
  assign push_entry_o.opens  = starts_frame_i;
  assign push_entry_o.closes = ends_frame_i;
  assign push_entry_o.sum    = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_q <= 1'b0;
      sum_q    <= 8'h00;
    end else if (push_o) begin
      toggle_q <= toggle_d;
      sum_q    <= sum_d;
    end
  end

endmodule

[sv/irenc_queue.sv]
// short queue of classified items between front and back end
module irenc_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  irenc_pkg::entry_t push_entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output irenc_pkg::entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  irenc_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/irenc_back.sv]
// back end: serialises header, bytes with complements and checksum
module irenc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  irenc_pkg::entry_t q_entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o
);

  logic              busy_q, busy_d;
  irenc_pkg::entry_t cur_q;
  irenc_pkg::step_e  step_q, step_d;
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  logic              load_ok, emit, last_step;
  logic [7:0]        byte_sel;

  assign load_ok   = !out_valid_q || !out_stall_i;
  assign emit      = busy_q && load_ok;
  assign last_step = ((step_q == irenc_pkg::StDataN) && !cur_q.closes) ||
                     (step_q == irenc_pkg::StSumN);
  assign pop_o     = q_valid_i && (!busy_q || (emit && last_step));

  always_comb begin
    unique case (step_q)
      irenc_pkg::StHdr0:  byte_sel = irenc_pkg::HdrByte0;
      irenc_pkg::StHdr1:  byte_sel = irenc_pkg::HdrByte1;
      irenc_pkg::StHdr2:  byte_sel = irenc_pkg::HdrByte2;
      irenc_pkg::StData:  byte_sel = cur_q.data;
      irenc_pkg::StDataN: byte_sel = ~cur_q.data;
      irenc_pkg::StSum:   byte_sel = cur_q.sum;
      irenc_pkg::StSumN:  byte_sel = ~cur_q.sum;
      default:            byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (emit) begin
      unique case (step_q)
        irenc_pkg::StHdr0:  step_d = irenc_pkg::StHdr1;
        irenc_pkg::StHdr1:  step_d = irenc_pkg::StHdr2;
        irenc_pkg::StHdr2:  step_d = irenc_pkg::StData;
        irenc_pkg::StData:  step_d = irenc_pkg::StDataN;
        irenc_pkg::StDataN: step_d = irenc_pkg::StSum;
        irenc_pkg::StSum:   step_d = irenc_pkg::StSumN;
        irenc_pkg::StSumN:  step_d = irenc_pkg::StHdr0;
        default:            step_d = irenc_pkg::StHdr0;
      endcase
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      step_d = q_entry_i.opens ? irenc_pkg::StHdr0 : irenc_pkg::StData;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_entry_i;
    end
    if (emit) begin
      out_byte_q <= byte_sel;
      out_last_q <= last_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= irenc_pkg::StHdr0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (load_ok) begin
        out_valid_q <= emit;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

[sv/ir_command_frame_encoder.sv]
// top level of the ir command frame encoder
// Takes message bytes (opcode opening a frame, then parameters, last one marked) and
// emits the serial frame: header 55 FF 00 for an opcode, every byte followed by its
// ones' complement, and after the marked byte the checksum and its complement. The
// opcode gets 0x08 added on every second frame. The output gives one byte per cycle
// from its own register unless out_stall_i holds it; a parameter item yields 2 bytes,
// an opcode 5, and 2 more when marked last, and the next item is popped as the last
// byte of the current one is emitted. Input is taken in the cycle it arrives while
// the Depth-entry queue between the classifying front end and the serialising back
// end has room; a byte then passes the queue, the item register and output register.
module ir_command_frame_encoder #(
  parameter int unsigned Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       starts_frame_i,
  input  logic       ends_frame_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  irenc_pkg::entry_t push_entry, q_entry;
  logic              push, full, pop, q_valid;

  irenc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .starts_frame_i (starts_frame_i),
    .ends_frame_i   (ends_frame_i),
    .full_i         (full),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  irenc_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .entry_o      (q_entry)
  );

  irenc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
